@@ hdl/dvru_pkg.sv @@
// shared types, codes and sizes for the distance-vector route table
// no dependencies

package dvru_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = $clog2(ENTRIES);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_ADVERT = 2'd2;
    localparam logic [1:0] OP_LOOKUP = 2'd3;

    localparam logic [2:0] ST_UNCHANGED = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_IMPROVED  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_HIT       = 3'd4;
    localparam logic [2:0] ST_MISS      = 3'd5;
    localparam logic [2:0] ST_DONE      = 3'd6;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] network;
        logic [7:0]  hops;
        logic [7:0]  via_router;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] route_hops;
        logic [7:0] route_next_hop;
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic match;
        logic exec;
    } dvru_cmd_t;

endpackage

@@ hdl/dvru_datapath.sv @@
// route table storage, parallel network match and update logic
// depends on dvru_pkg

module dvru_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  dvru_pkg::dvru_cmd_t cmd,
    input  dvru_pkg::item_t    item,
    output dvru_pkg::result_t  result
);

    dvru_pkg::item_t                      item_reg;
    logic [dvru_pkg::ENTRIES-1:0]         valid_reg;
    logic [dvru_pkg::ENTRIES-1:0]         valid_next;
    logic [dvru_pkg::ENTRIES-1:0]         match_reg;
    logic [dvru_pkg::ENTRIES-1:0]         free_reg;
    logic [15:0]                          net_mem [dvru_pkg::ENTRIES];
    logic [7:0]                           hops_mem [dvru_pkg::ENTRIES];
    logic [7:0]                           nh_mem [dvru_pkg::ENTRIES];
    dvru_pkg::result_t                    result_reg;
    dvru_pkg::result_t                    result_next;

    logic                                 hit;
    logic                                 has_free;
    logic [dvru_pkg::IDX_W-1:0]           hit_idx;
    logic [dvru_pkg::IDX_W-1:0]           free_idx;
    logic [dvru_pkg::IDX_W-1:0]           wr_idx;
    logic                                 wr_en;
    logic [7:0]                           wr_hops;
    logic [7:0]                           cur_hops;
    logic [7:0]                           cur_nh;
    logic [8:0]                           plus;
    logic [7:0]                           plus_sat;

    function automatic logic [dvru_pkg::IDX_W-1:0] first_set(
        input logic [dvru_pkg::ENTRIES-1:0] v
    );
        logic [dvru_pkg::IDX_W-1:0] r;
        r = '0;
        for (int i = dvru_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = dvru_pkg::IDX_W'(i);
            end
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
    end

    // match stage against the table as left by the previous item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '0;
            free_reg  <= '0;
        end
        else if (cmd.match)
        begin
            for (int i = 0; i < dvru_pkg::ENTRIES; i++)
            begin
                match_reg[i] <= valid_reg[i] && (net_mem[i] == item_reg.network);
            end
            free_reg <= ~valid_reg;
        end
    end

    assign hit      = |match_reg;
    assign has_free = |free_reg;
    assign hit_idx  = first_set(match_reg);
    assign free_idx = first_set(free_reg);
    assign cur_hops = hops_mem[hit_idx];
    assign cur_nh   = nh_mem[hit_idx];
    assign plus     = {1'b0, item_reg.hops} + 9'd1;
    assign plus_sat = plus[8] ? 8'hff : plus[7:0];

    always_comb
    begin
        wr_en       = 1'b0;
        wr_idx      = hit ? hit_idx : free_idx;
        wr_hops     = item_reg.hops;
        valid_next  = valid_reg;
        result_next = '{status: dvru_pkg::ST_UNCHANGED, route_hops: 8'd0,
                        route_next_hop: 8'd0};
        unique case (item_reg.opcode)
            dvru_pkg::OP_CLEAR:
            begin
                valid_next         = '0;
                result_next.status = dvru_pkg::ST_DONE;
            end
            dvru_pkg::OP_LOAD:
            begin
                if (hit || has_free)
                begin
                    wr_en       = 1'b1;
                    result_next = '{status: dvru_pkg::ST_DONE,
                                    route_hops: item_reg.hops,
                                    route_next_hop: item_reg.via_router};
                end
                else
                begin
                    result_next.status = dvru_pkg::ST_FULL;
                end
            end
            dvru_pkg::OP_ADVERT:
            begin
                if (hit)
                begin
                    if ({1'b0, cur_hops} > plus)
                    begin
                        wr_en       = 1'b1;
                        wr_hops     = plus[7:0];
                        result_next = '{status: dvru_pkg::ST_IMPROVED,
                                        route_hops: plus[7:0],
                                        route_next_hop: item_reg.via_router};
                    end
                    else
                    begin
                        result_next = '{status: dvru_pkg::ST_UNCHANGED,
                                        route_hops: cur_hops,
                                        route_next_hop: cur_nh};
                    end
                end
                else if (has_free)
                begin
                    wr_en       = 1'b1;
                    wr_hops     = plus_sat;
                    result_next = '{status: dvru_pkg::ST_INSERTED,
                                    route_hops: plus_sat,
                                    route_next_hop: item_reg.via_router};
                end
                else
                begin
                    result_next.status = dvru_pkg::ST_FULL;
                end
            end
            dvru_pkg::OP_LOOKUP:
            begin
                if (hit)
                begin
                    result_next = '{status: dvru_pkg::ST_HIT,
                                    route_hops: cur_hops,
                                    route_next_hop: cur_nh};
                end
                else
                begin
                    result_next.status = dvru_pkg::ST_MISS;
                end
            end
            default:
            begin
                result_next.status = dvru_pkg::ST_UNCHANGED;
            end
        endcase
        if (wr_en)
        begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.exec)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            net_mem[wr_idx]  <= item_reg.network;
            hops_mem[wr_idx] <= wr_hops;
            nh_mem[wr_idx]   <= item_reg.via_router;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

    a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_reg))
        else $error("network matched in more than one slot");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && item_reg.opcode == dvru_pkg::OP_CLEAR) |=> (valid_reg == '0))
        else $error("table not empty after clear");

    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && result_next.status == dvru_pkg::ST_FULL) |=> $stable(valid_reg))
        else $error("table changed on a full result");

endmodule

@@ hdl/dvru_ctrl.sv @@
// controller state machine: input capture, match and execute sequencing
// depends on dvru_pkg

module dvru_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    output logic                result_valid,
    input  logic                result_ready,
    output dvru_pkg::dvru_cmd_t cmd
);

    dvru_pkg::state_t state_reg;
    dvru_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dvru_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        item_ready  = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            dvru_pkg::S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = dvru_pkg::S_MATCH;
                end
            end
            dvru_pkg::S_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = dvru_pkg::S_EXEC;
            end
            dvru_pkg::S_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.exec   = 1'b1;
                    item_ready = 1'b1;
                    if (item_valid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = dvru_pkg::S_MATCH;
                    end
                    else
                    begin
                        state_next = dvru_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = dvru_pkg::S_IDLE;
            end
        endcase
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign result_valid = out_valid_reg;

    a_exec_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (!out_valid_reg || result_ready))
        else $error("result overwritten while waiting");

    a_capture_to_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == dvru_pkg::S_MATCH))
        else $error("captured beat not matched next cycle");

    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid_reg)
        else $error("executed beat produced no result");

endmodule

@@ hdl/distance_vector_route_update.sv @@
// top level of the distance-vector route table update block
// depends on dvru_pkg, dvru_ctrl, dvru_datapath
//
// item channel: item_valid / item_ready carry one request beat (opcode,
// network, hops, via_router). result channel: result_valid / result_ready
// carry one beat (status, route_hops, route_next_hop) for every request.
// a request is registered on acceptance, matched against all table slots
// in the next cycle and executed (table write plus result register load)
// once the result register is free or being taken. a new request can be
// accepted in the same cycle as the previous one executes; throughput is
// set by the match-then-execute sequence of the controller.
// reset empties the table (all slot valid bits cleared) and drops any
// pending result. when the receiver stalls, the result is held; one more
// request is accepted and matched, then waits in execute until the result
// register is taken.

module distance_vector_route_update (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  dvru_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output dvru_pkg::result_t result
);

    dvru_pkg::dvru_cmd_t cmd;

    dvru_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    dvru_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .result (result)
    );

endmodule
